// ===== sv/vaar_pkg.sv =====
// Package for the axis-angle vector rotator: fixed-point constants and the
// CORDIC arctangent table. No dependencies.
package vaar_pkg;

    // CORDIC word: Q30 with headroom for the gain and the angle accumulator.
    typedef logic signed [33:0] t_cw;

    // Angle constants in Q4.28, one guard bit for the wrap.
    localparam logic signed [32:0] PI_Q28      = 33'sd843314857;
    localparam logic signed [32:0] TWO_PI_Q28  = 33'sd1686629713;
    localparam logic signed [32:0] HALF_PI_Q28 = 33'sd421657428;

    // Largest folded angle word in Q30 (four times pi/2 in Q28).
    localparam t_cw Z_LIMIT = 34'sd1686629712;

    localparam t_cw ONE_Q30 = 34'sd1073741824;
    localparam logic signed [63:0] GAIN_Q30       = 64'sd652032874;
    localparam logic signed [63:0] GAIN_DELTA_Q30 = 64'sd434688583;

    // atan(2^-i) in Q30, rounded to nearest.
    function automatic t_cw atan_q30(input int unsigned i);
        t_cw r;
        case (i)
            0:  r = 34'sd843314857;
            1:  r = 34'sd497837829;
            2:  r = 34'sd263043837;
            3:  r = 34'sd133525159;
            4:  r = 34'sd67021687;
            5:  r = 34'sd33543516;
            6:  r = 34'sd16775851;
            7:  r = 34'sd8388437;
            8:  r = 34'sd4194283;
            9:  r = 34'sd2097149;
            10: r = 34'sd1048576;
            default: begin
                if (i <= 30) r = 34'sd1 <<< (30 - i);
                else         r = '0;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== sv/vaar_if.sv =====
// Valid/ready channel interfaces for the rotator's input and result words.
// Depends on nothing.
interface vaar_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic signed [31:0] angle;

    modport source (output valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle,
                    input ready);
    modport sink   (input valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle,
                    output ready);
endinterface

interface vaar_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic               saturated;

    modport source (output valid, rot_x, rot_y, rot_z, saturated, input ready);
    modport sink   (input valid, rot_x, rot_y, rot_z, saturated, output ready);
endinterface

// ===== sv/vaar_reduce.sv =====
// Two-stage angle reduction: wrap into [-pi, pi], then fold into [-pi/2, pi/2].
// Depends on vaar_pkg.
module vaar_reduce #(
    parameter int SW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic signed [31:0] i_angle,
    input  logic [SW-1:0]     i_side,
    output logic              o_vld,
    output vaar_pkg::t_cw     o_z,
    output logic              o_neg,
    output logic [SW-1:0]     o_side
);

    logic [1:0]             r_vld;
    logic signed [32:0]     r_a;
    logic [SW-1:0]          r_sd1;
    logic [SW-1:0]          r_sd2;
    vaar_pkg::t_cw          r_z;
    logic                   r_neg;
    logic signed [32:0]     n_a;
    logic signed [32:0]     a_in;
    logic signed [32:0]     n_f;
    logic                   n_neg;

    always_comb begin
        a_in = 33'(i_angle);
        if (a_in > vaar_pkg::PI_Q28) begin
            n_a = a_in - vaar_pkg::TWO_PI_Q28;
        end else if (a_in < -vaar_pkg::PI_Q28) begin
            n_a = a_in + vaar_pkg::TWO_PI_Q28;
        end else begin
            n_a = a_in;
        end
    end

    always_comb begin
        n_neg = 1'b1;
        if (r_a > vaar_pkg::HALF_PI_Q28) begin
            n_f = r_a - vaar_pkg::PI_Q28;
        end else if (r_a < -vaar_pkg::HALF_PI_Q28) begin
            n_f = r_a + vaar_pkg::PI_Q28;
        end else begin
            n_f   = r_a;
            n_neg = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a   <= n_a;
            r_sd1 <= i_side;
            r_z   <= 34'(n_f) <<< 2;
            r_neg <= n_neg;
            r_sd2 <= r_sd1;
        end
    end

    assign o_vld  = r_vld[1];
    assign o_z    = r_z;
    assign o_neg  = r_neg;
    assign o_side = r_sd2;

`ifndef SYNTHESIS
    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r_z <= vaar_pkg::Z_LIMIT && r_z >= -vaar_pkg::Z_LIMIT))
        else $error("folded angle outside [-pi/2, pi/2]");
`endif

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");
`endif

endmodule

// ===== sv/vaar_cross.sv =====
// Five-stage cross products w = k x v and u = k x w, with the wide products
// split into partial products. Depends on nothing outside this file.
module vaar_cross #(
    parameter int FRAC_BITS = 16,
    parameter int SW        = 1,
    localparam int WS       = 30 - FRAC_BITS,
    localparam int WW       = FRAC_BITS + 35,
    localparam int UW       = WW + 3
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  logic [2:0][31:0]       i_v,
    input  logic [2:0][31:0]       i_k,
    input  logic [SW-1:0]          i_side,
    output logic                   o_vld,
    output logic [2:0][31:0]       o_v,
    output logic [2:0][WW-1:0]     o_w,
    output logic [2:0][UW-1:0]     o_u,
    output logic [SW-1:0]          o_side
);

    localparam int HW = WW - 25;
    localparam int PW = 32 + WW;
    localparam int QW = WW + 2;

    logic [4:0]            r_vld;
    logic [2:0][31:0]      r_v  [5];
    logic [SW-1:0]         r_sd [5];
    logic [2:0][31:0]      r_k1;
    logic [2:0][31:0]      r_k2;
    logic signed [63:0]    r1_pa [3];
    logic signed [63:0]    r1_pb [3];
    logic [2:0][WW-1:0]    r2_w;
    logic [2:0][WW-1:0]    r3_w;
    logic [2:0][WW-1:0]    r4_w;
    logic [2:0][WW-1:0]    r5_w;
    logic signed [32+HW-1:0] r3_pah [3];
    logic signed [32+HW-1:0] r3_pbh [3];
    logic signed [57:0]    r3_pal [3];
    logic signed [57:0]    r3_pbl [3];
    logic signed [QW-1:0]  r4_qa [3];
    logic signed [QW-1:0]  r4_qb [3];
    logic [2:0][UW-1:0]    r5_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v[0]  <= i_v;
            r_sd[0] <= i_side;
            for (int s = 1; s < 5; s++) begin
                r_v[s]  <= r_v[s-1];
                r_sd[s] <= r_sd[s-1];
            end
            r_k1 <= i_k;
            r_k2 <= r_k1;
            r3_w <= r2_w;
            r4_w <= r3_w;
            r5_w <= r4_w;
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_comp
        localparam int A = (j + 1) % 3;
        localparam int B = (j + 2) % 3;
        logic signed [PW-1:0] full_a;
        logic signed [PW-1:0] full_b;

        // Partial products are rebuilt exactly, so the shift below is a floor.
        assign full_a = (PW'(r3_pah[j]) <<< 25) + PW'(r3_pal[j]);
        assign full_b = (PW'(r3_pbh[j]) <<< 25) + PW'(r3_pbl[j]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r1_pa[j]  <= $signed(i_k[A]) * $signed(i_v[B]);
                r1_pb[j]  <= $signed(i_k[B]) * $signed(i_v[A]);
                r2_w[j]   <= WW'(r1_pa[j] >>> WS) - WW'(r1_pb[j] >>> WS);
                r3_pah[j] <= $signed(r_k2[A]) * $signed(r2_w[B][WW-1:25]);
                r3_pal[j] <= $signed(r_k2[A]) * $signed({1'b0, r2_w[B][24:0]});
                r3_pbh[j] <= $signed(r_k2[B]) * $signed(r2_w[A][WW-1:25]);
                r3_pbl[j] <= $signed(r_k2[B]) * $signed({1'b0, r2_w[A][24:0]});
                r4_qa[j]  <= QW'(full_a >>> 30);
                r4_qb[j]  <= QW'(full_b >>> 30);
                r5_u[j]   <= UW'(r4_qa[j]) - UW'(r4_qb[j]);
            end
        end
    end

    assign o_vld  = r_vld[4];
    assign o_v    = r_v[4];
    assign o_w    = r5_w;
    assign o_u    = r5_u;
    assign o_side = r_sd[4];

endmodule

// ===== sv/vaar_cordic.sv =====
// Fully unrolled CORDIC rotation, one register stage per iteration.
// Depends on vaar_pkg.
module vaar_cordic #(
    parameter int STEPS = 24,
    parameter int SW    = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  vaar_pkg::t_cw  i_z,
    input  logic           i_neg,
    input  logic [SW-1:0]  i_side,
    output logic           o_vld,
    output vaar_pkg::t_cw  o_x,
    output vaar_pkg::t_cw  o_y,
    output logic           o_neg,
    output logic [SW-1:0]  o_side
);

    // Start value is the gain plus its correction term for this run length.
    localparam vaar_pkg::t_cw X0 = (2 * STEPS < 62) ?
        34'(vaar_pkg::GAIN_Q30 + (vaar_pkg::GAIN_DELTA_Q30 >>> (2 * STEPS))) :
        34'(vaar_pkg::GAIN_Q30);

    vaar_pkg::t_cw  r_x   [STEPS];
    vaar_pkg::t_cw  r_y   [STEPS];
    vaar_pkg::t_cw  r_z   [STEPS];
    logic [SW-1:0]  r_sd  [STEPS];
    logic           r_ng  [STEPS];
    logic           r_vld [STEPS];

    for (genvar gs = 0; gs < STEPS; gs++) begin : g_it
        vaar_pkg::t_cw xi;
        vaar_pkg::t_cw yi;
        vaar_pkg::t_cw zi;
        logic [SW-1:0] si;
        logic          ni;
        logic          vi;

        if (gs == 0) begin : g_first
            assign xi = X0;
            assign yi = '0;
            assign zi = i_z;
            assign si = i_side;
            assign ni = i_neg;
            assign vi = i_vld;
        end else begin : g_next
            assign xi = r_x[gs-1];
            assign yi = r_y[gs-1];
            assign zi = r_z[gs-1];
            assign si = r_sd[gs-1];
            assign ni = r_ng[gs-1];
            assign vi = r_vld[gs-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gs] <= 1'b0;
            end else if (i_en) begin
                r_vld[gs] <= vi;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!zi[33]) begin
                    r_x[gs] <= xi - (yi >>> gs);
                    r_y[gs] <= yi + (xi >>> gs);
                    r_z[gs] <= zi - vaar_pkg::atan_q30(gs);
                end else begin
                    r_x[gs] <= xi + (yi >>> gs);
                    r_y[gs] <= yi - (xi >>> gs);
                    r_z[gs] <= zi + vaar_pkg::atan_q30(gs);
                end
                r_sd[gs] <= si;
                r_ng[gs] <= ni;
            end
        end
    end

    assign o_vld  = r_vld[STEPS-1];
    assign o_x    = r_x[STEPS-1];
    assign o_y    = r_y[STEPS-1];
    assign o_neg  = r_ng[STEPS-1];
    assign o_side = r_sd[STEPS-1];

endmodule

// ===== sv/vaar_combine.sv =====
// Five-stage output: sin and 1 - cos, the two scaled terms, the sum with
// rounding, then saturation into the output register. Depends on vaar_pkg.
module vaar_combine #(
    parameter int FRAC_BITS = 16,
    localparam int WW       = FRAC_BITS + 35,
    localparam int UW       = WW + 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic [2:0][31:0]    i_v,
    input  logic [2:0][WW-1:0]  i_w,
    input  logic [2:0][UW-1:0]  i_u,
    input  vaar_pkg::t_cw       i_x,
    input  vaar_pkg::t_cw       i_y,
    input  logic                i_neg,
    output logic                o_vld,
    output logic [2:0][31:0]    o_rot,
    output logic                o_sat
);

    localparam int WHW = WW - 25;
    localparam int UHW = UW - 25;
    localparam int P1W = WW + 34;
    localparam int P2W = UW + 34;
    localparam int T1W = WW + 4;
    localparam int T2W = UW + 4;
    localparam int RW  = UW + 6;
    localparam int RRW = RW - FRAC_BITS;
    localparam logic signed [RW-1:0] RND = RW'(1) <<< (FRAC_BITS - 1);

    logic [4:0]               r_vld;
    logic [2:0][31:0]         r1_v;
    logic [2:0][31:0]         r2_v;
    logic [2:0][31:0]         r3_v;
    logic [2:0][WW-1:0]       r1_w;
    logic [2:0][UW-1:0]       r1_u;
    vaar_pkg::t_cw            r1_sn;
    vaar_pkg::t_cw            r1_omc;
    logic signed [WHW+33:0]   r2_wh [3];
    logic signed [59:0]       r2_wl [3];
    logic signed [UHW+33:0]   r2_uh [3];
    logic signed [59:0]       r2_ul [3];
    logic signed [T1W-1:0]    r3_t1 [3];
    logic signed [T2W-1:0]    r3_t2 [3];
    logic signed [RW-1:0]     r4_s  [3];
    logic [2:0][31:0]         r_rot;
    logic                     r_sat;
    logic [2:0]               n_clip;
    logic [2:0][31:0]         n_rot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_v   <= i_v;
            r1_w   <= i_w;
            r1_u   <= i_u;
            r1_sn  <= i_neg ? -i_y : i_y;
            // 1 - cos, with the fold's sign change on cos taken in here.
            r1_omc <= i_neg ? vaar_pkg::ONE_Q30 + i_x : vaar_pkg::ONE_Q30 - i_x;
            r2_v   <= r1_v;
            r3_v   <= r2_v;
            r_rot  <= n_rot;
            r_sat  <= |n_clip;
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_lane
        logic signed [P1W-1:0] p1;
        logic signed [P2W-1:0] p2;
        logic signed [RRW-1:0] rr;

        assign p1 = (P1W'(r2_wh[j]) <<< 25) + P1W'(r2_wl[j]);
        assign p2 = (P2W'(r2_uh[j]) <<< 25) + P2W'(r2_ul[j]);
        assign rr = RRW'(r4_s[j] >>> FRAC_BITS);

        always_comb begin
            if (&rr[RRW-1:31] || ~|rr[RRW-1:31]) begin
                n_clip[j] = 1'b0;
                n_rot[j]  = rr[31:0];
            end else begin
                n_clip[j] = 1'b1;
                n_rot[j]  = rr[RRW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r2_wh[j] <= $signed(r1_w[j][WW-1:25]) * r1_sn;
                r2_wl[j] <= $signed({1'b0, r1_w[j][24:0]}) * r1_sn;
                r2_uh[j] <= $signed(r1_u[j][UW-1:25]) * r1_omc;
                r2_ul[j] <= $signed({1'b0, r1_u[j][24:0]}) * r1_omc;
                r3_t1[j] <= T1W'(p1 >>> 30);
                r3_t2[j] <= T2W'(p2 >>> 30);
                r4_s[j]  <= (RW'($signed(r3_v[j])) <<< FRAC_BITS)
                          + RW'(r3_t1[j]) + RW'(r3_t2[j]) + RND;
            end
        end
    end

    assign o_vld = r_vld[4];
    assign o_rot = r_rot;
    assign o_sat = r_sat;

endmodule

// ===== sv/vector_axis_angle_rotate_top.sv =====
// Top level of the axis-angle vector rotator (Rodrigues' formula).
// Depends on vaar_pkg, vaar_if, vaar_reduce, vaar_cross, vaar_cordic, vaar_combine.
//
//  channel  direction  carries
//  i_in     in         vec_x/y/z (Q16.16), axis_x/y/z (Q2.30), angle (Q4.28)
//  o_out    out        rot_x/y/z (Q16.16), saturated
//
// One word is accepted per cycle while the output is not held; the stages are
// angle reduction 2, cross products 5, one per CORDIC iteration, output 5.
// Reset clears only the valid bits; payload registers are left as they are.
// When the output word is held, the whole pipeline holds and i_in.ready drops.
module vector_axis_angle_rotate_top #(
    parameter int CORDIC_STEPS = 24,
    parameter int FRAC_BITS    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vaar_in_if.sink     i_in,
    vaar_out_if.source  o_out
);

    localparam int WW  = FRAC_BITS + 35;
    localparam int UW  = WW + 3;
    localparam int CSW = 96 + 3 * WW + 3 * UW;

    logic               en;
    logic [2:0][31:0]   in_v;
    logic [2:0][31:0]   in_k;

    logic               red_vld;
    vaar_pkg::t_cw      red_z;
    logic               red_neg;
    logic [191:0]       red_side;

    logic               cr_vld;
    logic [2:0][31:0]   cr_v;
    logic [2:0][WW-1:0] cr_w;
    logic [2:0][UW-1:0] cr_u;
    logic [34:0]        cr_side;

    logic               co_vld;
    vaar_pkg::t_cw      co_x;
    vaar_pkg::t_cw      co_y;
    logic               co_neg;
    logic [CSW-1:0]     co_side;
    logic [2:0][31:0]   co_v;
    logic [2:0][WW-1:0] co_w;
    logic [2:0][UW-1:0] co_u;

    logic [2:0][31:0]   rot;

    assign en = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    assign in_v[0] = i_in.vec_x;
    assign in_v[1] = i_in.vec_y;
    assign in_v[2] = i_in.vec_z;
    assign in_k[0] = i_in.axis_x;
    assign in_k[1] = i_in.axis_y;
    assign in_k[2] = i_in.axis_z;

    vaar_reduce #(.SW(192)) u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_in.valid),
        .i_angle (i_in.angle),
        .i_side  ({in_v, in_k}),
        .o_vld   (red_vld),
        .o_z     (red_z),
        .o_neg   (red_neg),
        .o_side  (red_side)
    );

    vaar_cross #(.FRAC_BITS(FRAC_BITS), .SW(35)) u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (red_vld),
        .i_v     (red_side[191:96]),
        .i_k     (red_side[95:0]),
        .i_side  ({red_z, red_neg}),
        .o_vld   (cr_vld),
        .o_v     (cr_v),
        .o_w     (cr_w),
        .o_u     (cr_u),
        .o_side  (cr_side)
    );

    vaar_cordic #(.STEPS(CORDIC_STEPS), .SW(CSW)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (cr_vld),
        .i_z     (cr_side[34:1]),
        .i_neg   (cr_side[0]),
        .i_side  ({cr_v, cr_w, cr_u}),
        .o_vld   (co_vld),
        .o_x     (co_x),
        .o_y     (co_y),
        .o_neg   (co_neg),
        .o_side  (co_side)
    );

    assign {co_v, co_w, co_u} = co_side;

    vaar_combine #(.FRAC_BITS(FRAC_BITS)) u_combine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (co_vld),
        .i_v     (co_v),
        .i_w     (co_w),
        .i_u     (co_u),
        .i_x     (co_x),
        .i_y     (co_y),
        .i_neg   (co_neg),
        .o_vld   (o_out.valid),
        .o_rot   (rot),
        .o_sat   (o_out.saturated)
    );

    assign o_out.rot_x = rot[0];
    assign o_out.rot_y = rot[1];
    assign o_out.rot_z = rot[2];

`ifndef SYNTHESIS
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.saturated) |->
            (o_out.rot_x == 32'sh7fff_ffff || o_out.rot_x == 32'sh8000_0000 ||
             o_out.rot_y == 32'sh7fff_ffff || o_out.rot_y == 32'sh8000_0000 ||
             o_out.rot_z == 32'sh7fff_ffff || o_out.rot_z == 32'sh8000_0000))
        else $error("saturated word has no component on a rail");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the axis-angle vector rotator: drives words on i_in,
// predicts each rotated vector and checks o_out. Depends on vaar_pkg, vaar_if and the top.
module tb;

    localparam int STEPS = 24;
    localparam int FB    = 16;
    localparam int N_RAND = 1850;
    localparam int LIMIT = 2000000;

    typedef struct packed {
        logic signed [31:0] vx, vy, vz, kx, ky, kz, ang;
    } t_item;

    typedef struct packed {
        logic signed [31:0] rx, ry, rz;
        logic               sat;
    } t_rot;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    vaar_in_if  in_if();
    vaar_out_if out_if();

    vector_axis_angle_rotate_top #(.CORDIC_STEPS(STEPS), .FRAC_BITS(FB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_if.sink), .o_out(out_if.source)
    );

    always #5 i_clk = ~i_clk;

    t_item pending_q[$];
    t_rot  rot_q[$];
    int    n_err = 0;
    int    n_rot = 0;
    int    n_sat = 0;
    int    cycles = 0;
    bit    calm = 1'b0;
    bit    hold_send = 1'b0;
    bit    done_feed = 1'b0;

    // floor(a*b / 2^sh), exact in 128 bits
    function automatic longint fmul(longint a, longint b, int sh);
        logic signed [127:0] p;
        p = 128'(signed'(a)) * 128'(signed'(b));
        p = p >>> sh;
        return longint'(p);
    endfunction

    function automatic t_rot rotate_vec(t_item it);
        longint a, x, y, z, dx, dy, sn, cs, omc, r;
        longint v[3], k[3], w[3], u[3];
        bit flip;
        t_rot res;
        int ia, ib;
        v[0] = it.vx; v[1] = it.vy; v[2] = it.vz;
        k[0] = it.kx; k[1] = it.ky; k[2] = it.kz;
        a = it.ang;
        flip = 1'b0;
        if (a > vaar_pkg::PI_Q28) a -= vaar_pkg::TWO_PI_Q28;
        else if (a < -vaar_pkg::PI_Q28) a += vaar_pkg::TWO_PI_Q28;
        if (a > vaar_pkg::HALF_PI_Q28) begin
            a -= vaar_pkg::PI_Q28; flip = 1'b1;
        end else if (a < -vaar_pkg::HALF_PI_Q28) begin
            a += vaar_pkg::PI_Q28; flip = 1'b1;
        end
        x = vaar_pkg::GAIN_Q30;
        if (2 * STEPS < 62) x += vaar_pkg::GAIN_DELTA_Q30 >>> (2 * STEPS);
        y = 0;
        z = a * 4;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(vaar_pkg::atan_q30(i));
            end else begin
                x += dx; y -= dy; z += longint'(vaar_pkg::atan_q30(i));
            end
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
        omc = longint'(vaar_pkg::ONE_Q30) - cs;
        for (int j = 0; j < 3; j++) begin
            ia = (j + 1) % 3; ib = (j + 2) % 3;
            w[j] = fmul(k[ia], v[ib], 30 - FB) - fmul(k[ib], v[ia], 30 - FB);
        end
        for (int j = 0; j < 3; j++) begin
            ia = (j + 1) % 3; ib = (j + 2) % 3;
            u[j] = fmul(k[ia], w[ib], 30) - fmul(k[ib], w[ia], 30);
        end
        res.sat = 1'b0;
        for (int j = 0; j < 3; j++) begin
            r = (v[j] <<< FB) + fmul(w[j], sn, 30) + fmul(u[j], omc, 30);
            r = (r + (64'sd1 <<< (FB - 1))) >>> FB;
            if (r > 64'sd2147483647) begin
                r = 64'sd2147483647; res.sat = 1'b1;
            end else if (r < -64'sd2147483648) begin
                r = -64'sd2147483648; res.sat = 1'b1;
            end
            if (j == 0) res.rx = r[31:0];
            else if (j == 1) res.ry = r[31:0];
            else res.rz = r[31:0];
        end
        return res;
    endfunction

    function automatic logic [31:0] unit_q30();
        // Components of a roughly unit axis: mostly below one in magnitude.
        return 32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
    endfunction

    function automatic t_item rand_item();
        t_item it;
        int m;
        m = $urandom_range(0, 9);
        it.vx = $urandom; it.vy = $urandom; it.vz = $urandom;
        if (m < 6) begin
            // Moderate vectors so most words do not clip.
            it.vx = $signed(it.vx) >>> $urandom_range(0, 12);
            it.vy = $signed(it.vy) >>> $urandom_range(0, 12);
            it.vz = $signed(it.vz) >>> $urandom_range(0, 12);
        end
        case ($urandom_range(0, 3))
            0: begin
                it.kx = 32'sh4000_0000; it.ky = 0; it.kz = 0;
            end
            1: begin
                it.kx = 0; it.ky = 0;
                it.kz = ($urandom & 1) ? 32'sh4000_0000 : 32'shC000_0000;
            end
            2: begin
                it.kx = unit_q30(); it.ky = unit_q30(); it.kz = unit_q30();
            end
            default: begin
                it.kx = $urandom; it.ky = $urandom; it.kz = $urandom;
            end
        endcase
        it.ang = $urandom;
        return it;
    endfunction

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            if (pending_q.size() > 0 && !hold_send &&
                (calm || $urandom_range(0, 99) >= 32)) begin
                t_item it;
                it = pending_q.pop_front();
                rot_q.push_back(rotate_vec(it));
                in_if.valid  <= 1'b1;
                in_if.vec_x  <= it.vx;
                in_if.vec_y  <= it.vy;
                in_if.vec_z  <= it.vz;
                in_if.axis_x <= it.kx;
                in_if.axis_y <= it.ky;
                in_if.axis_z <= it.kz;
                in_if.angle  <= it.ang;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Monitor and result-side stalls
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= calm || ($urandom_range(0, 99) >= 32);
            if (out_if.valid && out_if.ready) begin
                t_rot e;
                n_rot <= n_rot + 1;
                if (out_if.saturated) n_sat <= n_sat + 1;
                if (rot_q.size() == 0) begin
                    $display("%0t: unexpected word x=%0d y=%0d z=%0d sat=%0b", $time,
                             out_if.rot_x, out_if.rot_y, out_if.rot_z, out_if.saturated);
                    n_err <= n_err + 1;
                end else begin
                    e = rot_q.pop_front();
                    if (e.rx !== out_if.rot_x || e.ry !== out_if.rot_y ||
                        e.rz !== out_if.rot_z || e.sat !== out_if.saturated) begin
                        $display({"%0t: expected x=%0d y=%0d z=%0d sat=%0b, ",
                                  "got x=%0d y=%0d z=%0d sat=%0b"},
                                 $time, e.rx, e.ry, e.rz, e.sat, out_if.rot_x, out_if.rot_y,
                                 out_if.rot_z, out_if.saturated);
                        n_err <= n_err + 1;
                    end
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic t_item mk(logic [31:0] vx, vy, vz, kx, ky, kz, ang);
        t_item it;
        it.vx = vx; it.vy = vy; it.vz = vz;
        it.kx = kx; it.ky = ky; it.kz = kz; it.ang = ang;
        return it;
    endfunction

    initial begin
        in_if.valid = 1'b0;
        in_if.vec_x = 0; in_if.vec_y = 0; in_if.vec_z = 0;
        in_if.axis_x = 0; in_if.axis_y = 0; in_if.axis_z = 0; in_if.angle = 0;
        out_if.ready = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: angle extremes and wraps, axis extremes, clipping, unit axes.
        pending_q.push_back(mk(32'h0001_0000, 0, 0, 0, 0, 32'h4000_0000, 32'd421657428));
        pending_q.push_back(mk(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                               32'h4000_0000, 0, 0, 32'd843314857));
        pending_q.push_back(mk(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                               0, 32'h4000_0000, 0, -32'sd843314858));
        pending_q.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_q.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        pending_q.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 0,
                               0, 0, 32'h4000_0000, 32'd421657429));
        pending_q.push_back(mk(32'h7FFF_FFFF, 0, 32'h8000_0000,
                               0, 32'h4000_0000, 0, 32'd843314857));
        pending_q.push_back(mk(32'h1234_5678, 32'hFEDC_BA98, 32'h0F0F_0F0F,
                               32'h2000_0000, 32'h2000_0000, 32'h2000_0000, 32'd1000000000));
        pending_q.push_back(mk(0, 0, 0, 32'h4000_0000, 0, 0, 32'd12345));
        pending_q.push_back(mk(32'hFFFF_FFFF, 1, 32'hFFFF_0000,
                               32'hC000_0000, 0, 0, -32'sd421657428));
        pending_q.push_back(mk(32'h0010_0000, 32'h0020_0000, 32'hFFF0_0000,
                               32'h0000_0001, 32'hFFFF_FFFF, 0, 32'd1686629713));
        pending_q.push_back(mk(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333,
                               32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, -32'sd1686629713));

        // A long calm stretch, then random idling on both sides.
        calm = 1'b1;
        for (int i = 0; i < 300; i++) pending_q.push_back(rand_item());
        wait (pending_q.size() == 0);
        calm = 1'b0;
        for (int i = 0; i < 500; i++) pending_q.push_back(rand_item());
        wait (pending_q.size() == 0);
        // Let the pipeline drain fully before feeding again.
        hold_send = 1'b1;
        wait (rot_q.size() == 0);
        hold_send = 1'b0;
        for (int i = 0; i < N_RAND - 800; i++) pending_q.push_back(rand_item());
        wait (pending_q.size() == 0);
        wait (rot_q.size() == 0);
        repeat (STEPS + 40) @(posedge i_clk);

        $display("Checked %0d rotated vectors, %0d of them clipped, %s",
                 n_rot, n_sat, "with random stalls on both sides.");
        if (n_err == 0 && rot_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/vaar_pkg.sv
sv/vaar_if.sv
sv/vaar_reduce.sv
sv/vaar_cross.sv
sv/vaar_cordic.sv
sv/vaar_combine.sv
sv/vector_axis_angle_rotate_top.sv
dv/tb.sv
